@@ hw/rtl/mst_pkg.sv @@
// Shared types and constants for the dense-matrix minimum spanning tree block.
// Used by mst_cell, mst_adj_mem and prim_mst_dense_matrix; depends on nothing.
package mst_pkg;

  // Default vertex capacity of the block.
  localparam int unsigned MaxVerticesDef = 64;

  // Field widths of the transfer payloads.
  localparam int unsigned WeightW   = 32;
  localparam int unsigned VtxFieldW = 6;
  localparam int unsigned VtxCountW = 7;

  // Vertex count register value after reset.
  localparam logic [VtxCountW-1:0] VtxCountRst = 7'd64;

  // Weight that marks a missing edge.
  localparam logic signed [WeightW-1:0] NoEdge = 32'sh7fff_ffff;

  // Request codes.
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqRun  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StPass,
    StEmit
  } state_e;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear;  // start of a run: drop all visited marks but vertex 0
    logic mark;   // mark the current row vertex as visited
    logic init;   // first pass: load best weights straight from the row
  } cell_ctl_t;

endpackage

@@ hw/rtl/prim_mst_dense_matrix.sv @@
// Prim minimum spanning tree over a dense adjacency matrix, cell chain top level.
// Each round of a run streams one matrix row from the single memory read port
// through the n active cells, and an output stall can hold a round before its
// edge is emitted.
// Reset clears the visited marks and sets the vertex count to 64; matrix entries
// are undefined until loaded.
module prim_mst_dense_matrix #(
  parameter int unsigned MaxVertices = mst_pkg::MaxVerticesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vertex_count_we_i,
  input  logic [mst_pkg::VtxCountW-1:0]        vertex_count_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [mst_pkg::VtxFieldW-1:0]        row_i,
  input  logic [mst_pkg::VtxFieldW-1:0]        col_i,
  input  logic signed [mst_pkg::WeightW-1:0]   weight_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mst_pkg::VtxFieldW-1:0]        parent_o,
  output logic [mst_pkg::VtxFieldW-1:0]        child_o,
  output logic signed [mst_pkg::WeightW-1:0]   edge_weight_o,
  output logic                                 unreachable_o,
  output logic                                 last_o
);
  import mst_pkg::*;

  localparam int unsigned VW = $clog2(MaxVertices);
  localparam int unsigned NW = $clog2(MaxVertices + 1);
  localparam int unsigned CW = (NW > VtxCountW) ? NW : VtxCountW;
  localparam int unsigned AW = 2 * VW;

  state_e                    state_q, state_d;
  logic [VtxCountW-1:0]      vertex_count_q;
  logic [CW-1:0]             vc_ext, n_clamp;
  logic [NW-1:0]             n_act;
  logic [NW-1:0]             addr_q;
  logic [NW-1:0]             round_q;
  logic [VW-1:0]             ch_q;
  logic                      init_q;
  logic                      first_q;
  logic                      accept, run_start, mem_we, issue, capture, emit;
  logic                      out_free, last_round;
  cell_ctl_t                 ctl;
  logic signed [WeightW-1:0] row_w;
  logic [MaxVertices-1:0]    cell_active;
  logic [MaxVertices:0]      tok_vld;
  logic [MaxVertices:0]      tok_fnd;
  logic signed [WeightW-1:0] tok_w   [MaxVertices+1];
  logic [VW-1:0]             tok_par [MaxVertices+1];
  logic [VW-1:0]             tok_idx [MaxVertices+1];
  logic signed [WeightW-1:0] res_w_q;
  logic [VW-1:0]             res_par_q;
  logic                      res_fnd_q;
  logic                      out_valid_q;
  logic [VtxFieldW-1:0]      out_par_q, out_ch_q;
  logic signed [WeightW-1:0] out_w_q;
  logic                      out_unr_q, out_last_q;

  // Active vertex count, clamped to the supported range.
  always_comb begin
    vc_ext = CW'(vertex_count_q);
    if (vc_ext < CW'(2)) begin
      n_clamp = CW'(2);
    end else if (vc_ext > CW'(MaxVertices)) begin
      n_clamp = CW'(MaxVertices);
    end else begin
      n_clamp = vc_ext;
    end
    n_act = NW'(n_clamp);
  end

  assign last_round = (round_q == (n_act - NW'(2)));

  // Next-state logic of the run sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (run_start) begin
          state_d = StPass;
        end
      end
      StPass: begin
        if (capture) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit) begin
          state_d = last_round ? StIdle : StPass;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control outputs of the run sequencer.
  always_comb begin
    in_stall_o = (state_q != StIdle);
    accept     = in_valid_i && !in_stall_o;
    run_start  = accept && (req_type_i == ReqRun);
    mem_we     = accept && (req_type_i == ReqLoad) &&
                 (32'(row_i) < MaxVertices) && (32'(col_i) < MaxVertices);
    out_free   = !out_valid_q || !out_stall_i;
    issue      = 1'b0;
    capture    = 1'b0;
    emit       = 1'b0;
    case (state_q)
      StPass: begin
        issue   = (addr_q < n_act);
        capture = tok_vld[n_act];
      end
      StEmit: begin
        emit = out_free;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    ctl.clear = run_start;
    ctl.mark  = emit;
    ctl.init  = init_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      vertex_count_q <= VtxCountRst;
      addr_q         <= '0;
      round_q        <= '0;
      init_q         <= 1'b0;
      first_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (vertex_count_we_i) begin
        vertex_count_q <= vertex_count_i;
      end
      first_q <= issue && (addr_q == '0);
      if (run_start) begin
        addr_q  <= '0;
        round_q <= '0;
        init_q  <= 1'b1;
      end else begin
        if (issue) begin
          addr_q <= addr_q + NW'(1);
        end
        if (capture) begin
          init_q <= 1'b0;
        end
        if (emit) begin
          addr_q  <= '0;
          round_q <= round_q + NW'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Round result and output register payload.
  always_ff @(posedge clk_i) begin
    if (run_start) begin
      ch_q <= '0;
    end else if (capture) begin
      ch_q <= tok_idx[n_act];
    end
    if (capture) begin
      res_w_q   <= tok_w[n_act];
      res_par_q <= tok_par[n_act];
      res_fnd_q <= tok_fnd[n_act];
    end
    if (emit) begin
      out_par_q  <= VtxFieldW'(res_par_q);
      out_ch_q   <= VtxFieldW'(ch_q);
      out_w_q    <= res_w_q;
      out_unr_q  <= !res_fnd_q;
      out_last_q <= last_round;
    end
  end

  // Adjacency matrix, addressed by row vertex then column vertex.
  mst_adj_mem #(
    .AddrW (AW)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({VW'(row_i), VW'(col_i)}),
    .wdata_i (weight_i),
    .re_i    (issue),
    .raddr_i ({ch_q, addr_q[VW-1:0]}),
    .rdata_o (row_w)
  );

  // The running minimum enters the chain with no candidate.
  assign tok_vld[0] = first_q;
  assign tok_w[0]   = NoEdge;
  assign tok_par[0] = '0;
  assign tok_idx[0] = '0;
  assign tok_fnd[0] = 1'b0;

  // Row of vertex cells; the token moves one cell per cycle with the row stream.
  for (genvar g = 0; g < MaxVertices; g++) begin : g_cell
    assign cell_active[g] = (NW'(g) < n_act);

    mst_cell #(
      .MaxVertices (MaxVertices),
      .Index       (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .active_i  (cell_active[g]),
      .ch_i      (ch_q),
      .row_w_i   (row_w),
      .tok_vld_i (tok_vld[g]),
      .tok_w_i   (tok_w[g]),
      .tok_par_i (tok_par[g]),
      .tok_idx_i (tok_idx[g]),
      .tok_fnd_i (tok_fnd[g]),
      .tok_vld_o (tok_vld[g+1]),
      .tok_w_o   (tok_w[g+1]),
      .tok_par_o (tok_par[g+1]),
      .tok_idx_o (tok_idx[g+1]),
      .tok_fnd_o (tok_fnd[g+1])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign parent_o      = out_par_q;
  assign child_o       = out_ch_q;
  assign edge_weight_o = out_w_q;
  assign unreachable_o = out_unr_q;
  assign last_o        = out_last_q;

  // At most one running-minimum token is in the chain at any time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one token in the cell chain");

  // A pass ends only after every element of its row has been read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |-> (addr_q == n_act))
    else $error("pass finished before the row was fully read");

  // The round counter stays below the number of tree edges during a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (({1'b0, round_q} + 1'b1) < {1'b0, n_act}))
    else $error("round counter ran past the last tree edge");

  // The token leaves the active chain only while a pass is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_vld[n_act] |-> (state_q == StPass))
    else $error("token arrived outside a pass");

endmodule

@@ hw/rtl/mst_adj_mem.sv @@
// Adjacency weight memory: one write port and one registered read port.
// Depends on mst_pkg for the weight width.
module mst_adj_mem #(
  parameter int unsigned AddrW = 12
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AddrW-1:0]                   waddr_i,
  input  logic signed [mst_pkg::WeightW-1:0] wdata_i,
  input  logic                               re_i,
  input  logic [AddrW-1:0]                   raddr_i,
  output logic signed [mst_pkg::WeightW-1:0] rdata_o
);
  import mst_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;

  logic signed [WeightW-1:0] mem_q [Depth];
  logic signed [WeightW-1:0] rdata_q;

  // Write on a load, read one row element per cycle during a pass.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mst_cell.sv @@
// One vertex cell: holds best weight, parent and visited mark of its vertex,
// relaxes against the streamed row element and passes the running minimum on.
// Depends on mst_pkg.
module mst_cell #(
  parameter int unsigned MaxVertices = mst_pkg::MaxVerticesDef,
  parameter int unsigned Index       = 0,
  localparam int unsigned VW         = $clog2(MaxVertices)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mst_pkg::cell_ctl_t                 ctl_i,
  input  logic                               active_i,
  input  logic [VW-1:0]                      ch_i,
  input  logic signed [mst_pkg::WeightW-1:0] row_w_i,
  input  logic                               tok_vld_i,
  input  logic signed [mst_pkg::WeightW-1:0] tok_w_i,
  input  logic [VW-1:0]                      tok_par_i,
  input  logic [VW-1:0]                      tok_idx_i,
  input  logic                               tok_fnd_i,
  output logic                               tok_vld_o,
  output logic signed [mst_pkg::WeightW-1:0] tok_w_o,
  output logic [VW-1:0]                      tok_par_o,
  output logic [VW-1:0]                      tok_idx_o,
  output logic                               tok_fnd_o
);
  import mst_pkg::*;

  localparam logic [VW-1:0] MyIdx = VW'(Index);

  logic                      visited_q;
  logic signed [WeightW-1:0] best_q;
  logic [VW-1:0]             par_q;
  logic signed [WeightW-1:0] new_w;
  logic [VW-1:0]             new_par;
  logic                      take;
  logic                      tok_vld_q;
  logic signed [WeightW-1:0] tok_w_q;
  logic [VW-1:0]             tok_par_q;
  logic [VW-1:0]             tok_idx_q;
  logic                      tok_fnd_q;

  // Relax this vertex with the row element, then compare with the running minimum.
  always_comb begin
    new_w   = best_q;
    new_par = par_q;
    if (ctl_i.init) begin
      new_w   = row_w_i;
      new_par = ch_i;
    end else if (!visited_q && (best_q > row_w_i)) begin
      new_w   = row_w_i;
      new_par = ch_i;
    end
    take = !visited_q && (new_w < tok_w_i);
  end

  // Visited mark and token valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        visited_q <= (Index == 0);
      end else if (ctl_i.mark && (ch_i == MyIdx)) begin
        visited_q <= 1'b1;
      end
      tok_vld_q <= tok_vld_i && active_i;
    end
  end

  // Vertex state and token payload.
  always_ff @(posedge clk_i) begin
    if (tok_vld_i && active_i) begin
      best_q <= new_w;
      par_q  <= new_par;
      if (take) begin
        tok_w_q   <= new_w;
        tok_par_q <= new_par;
        tok_idx_q <= MyIdx;
        tok_fnd_q <= 1'b1;
      end else begin
        tok_w_q   <= tok_w_i;
        tok_par_q <= tok_par_i;
        tok_idx_q <= tok_idx_i;
        tok_fnd_q <= tok_fnd_i;
      end
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_w_o   = tok_w_q;
  assign tok_par_o = tok_par_q;
  assign tok_idx_o = tok_idx_q;
  assign tok_fnd_o = tok_fnd_q;

endmodule
